// ===== sv/usb_control_request_handler_macros.svh =====
// assertion macros for the usb control request handler checker
`ifndef USB_CONTROL_REQUEST_HANDLER_MACROS_SVH
`define USB_CONTROL_REQUEST_HANDLER_MACROS_SVH

// same-cycle implication, sampled on the rising clock, off during reset
`define USBCTL_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on the rising clock, off during reset
`define USBCTL_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/usbctl_pkg.sv =====
// shared types, request codes and descriptor rom for the usb control request handler
package usbctl_pkg;

   // request codes
   localparam logic [7:0] REQ_GET_STATUS    = 8'h00;
   localparam logic [7:0] REQ_CLEAR_FEATURE = 8'h01;
   localparam logic [7:0] REQ_SET_FEATURE   = 8'h03;
   localparam logic [7:0] REQ_SET_ADDRESS   = 8'h05;
   localparam logic [7:0] REQ_GET_DESC      = 8'h06;
   localparam logic [7:0] REQ_GET_CONFIG    = 8'h08;
   localparam logic [7:0] REQ_SET_CONFIG    = 8'h09;
   localparam logic [7:0] REQ_VENDOR        = 8'h7f;

   // request types
   localparam logic [7:0] RT_STD_OUT      = 8'b0000_0000;
   localparam logic [7:0] RT_STD_IN       = 8'b1000_0000;
   localparam logic [7:0] RT_STD_IN_IFACE = 8'h81;
   localparam logic [7:0] RT_STD_IN_EP    = 8'h82;
   localparam logic [7:0] RT_VENDOR_OUT   = 8'b0100_0010;
   localparam logic [7:0] RT_VENDOR_IN    = 8'b1100_0010;

   // descriptor types
   localparam logic [7:0] DT_DEVICE = 8'h01;
   localparam logic [7:0] DT_CONFIG = 8'h02;
   localparam logic [7:0] DT_STRING = 8'h03;

   // csr register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_VENDOR_ID      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PRODUCT_ID     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DEVICE_RELEASE = 2'd2;

   localparam logic [15:0] VENDOR_ID_RST      = 16'h1234;
   localparam logic [15:0] PRODUCT_ID_RST     = 16'h1234;
   localparam logic [15:0] DEVICE_RELEASE_RST = 16'h0100;

   localparam int MAX_PACKET = 64;

   // state memory: configuration value and user value
   localparam int SMEM_DEPTH = 2;
   localparam int SMEM_AW    = 1;
   localparam int SMEM_WIDTH = 16;
   localparam logic [SMEM_AW-1:0] ENT_CONF = 1'b0;
   localparam logic [SMEM_AW-1:0] ENT_USER = 1'b1;

   typedef struct packed {
      logic                  rd_en;
      logic [SMEM_AW-1:0]    rd_addr;
      logic                  wr_en;
      logic [SMEM_AW-1:0]    wr_addr;
      logic [SMEM_WIDTH-1:0] wr_data;
   } smem_req_type;

   typedef struct packed {
      logic [15:0] vendor_id;
      logic [15:0] product_id;
      logic [15:0] device_release;
   } csr_regs_type;

   typedef enum logic [2:0] {
      DSEL_NONE,
      DSEL_DEV,
      DSEL_CFG,
      DSEL_STR0,
      DSEL_STR1,
      DSEL_STR2
   } dsel_type;

   localparam int CONF_DESC_LEN = 18;
   localparam logic [7:0] CONF_DESC [CONF_DESC_LEN] = '{
      8'd9, 8'd2, 8'd18, 8'd0, 8'd1, 8'd1, 8'd0, 8'h80, 8'd10,
      8'd9, 8'd4, 8'd0, 8'd0, 8'd0, 8'hff, 8'hff, 8'hff, 8'd0
   };

   // product name characters of string one
   localparam int PROD_LEN = 9;
   localparam logic [7:0] PROD_CHARS [PROD_LEN] = '{
      8'h73, 8'h69, 8'h6d, 8'h70, 8'h6c, 8'h65, 8'h75, 8'h73, 8'h62
   };

   function automatic logic [4:0] desc_len(input dsel_type dsel);
      logic [4:0] n;
      n = 5'd0;
      case (dsel)
         DSEL_DEV:  n = 5'd18;
         DSEL_CFG:  n = 5'd18;
         DSEL_STR0: n = 5'd4;
         DSEL_STR1: n = 5'd20;
         DSEL_STR2: n = 5'd6;
         default:   n = 5'd0;
      endcase
      return n;
   endfunction

   function automatic logic [7:0] desc_byte(input dsel_type dsel, input logic [4:0] pos,
                                            input csr_regs_type csr);
      logic [7:0] b;
      logic [3:0] ci;
      b  = 8'h00;
      ci = pos[4:1] - 4'd1;
      case (dsel)
         DSEL_DEV: begin
            case (pos)
               5'd0:    b = 8'd18;
               5'd1:    b = 8'd1;
               5'd2:    b = 8'h00;
               5'd3:    b = 8'h02;
               5'd4:    b = 8'hff;
               5'd5:    b = 8'hff;
               5'd6:    b = 8'hff;
               5'd7:    b = 8'(MAX_PACKET);
               5'd8:    b = csr.vendor_id[7:0];
               5'd9:    b = csr.vendor_id[15:8];
               5'd10:   b = csr.product_id[7:0];
               5'd11:   b = csr.product_id[15:8];
               5'd12:   b = csr.device_release[7:0];
               5'd13:   b = csr.device_release[15:8];
               5'd14:   b = 8'd0;
               5'd15:   b = 8'd1;
               5'd16:   b = 8'd2;
               5'd17:   b = 8'd1;
               default: b = 8'h00;
            endcase
         end
         DSEL_CFG: begin
            if (pos < 5'(CONF_DESC_LEN)) begin
               b = CONF_DESC[pos];
            end
         end
         DSEL_STR0: begin
            case (pos)
               5'd0:    b = 8'd4;
               5'd1:    b = 8'd3;
               5'd2:    b = 8'h09;
               5'd3:    b = 8'h04;
               default: b = 8'h00;
            endcase
         end
         DSEL_STR1: begin
            if (pos == 5'd0) begin
               b = 8'd20;
            end else if (pos == 5'd1) begin
               b = 8'd3;
            end else if (!pos[0] && ci < 4'(PROD_LEN)) begin
               b = PROD_CHARS[ci];
            end
         end
         DSEL_STR2: begin
            case (pos)
               5'd0:    b = 8'd6;
               5'd1:    b = 8'd3;
               5'd2:    b = 8'h34;
               5'd4:    b = 8'h32;
               default: b = 8'h00;
            endcase
         end
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

// ===== sv/usbctl_if.sv =====
// request and response channel interfaces
interface usbctl_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  request_type;
   logic [7:0]  request_code;
   logic [15:0] request_value;
   logic [15:0] request_length;
   logic [15:0] out_word;
   logic        status_out_seen;

   modport source (
      output valid, request_type, request_code, request_value, request_length,
             out_word, status_out_seen,
      input  ready
   );
   modport sink (
      input  valid, request_type, request_code, request_value, request_length,
             out_word, status_out_seen,
      output ready
   );
endinterface

interface usbctl_rsp_if;
   logic       valid;
   logic       ready;
   logic       item_kind;
   logic [7:0] data_byte;
   logic       stall_res;
   logic [6:0] device_address;
   logic       address_enabled;
   logic       last;

   modport source (
      output valid, item_kind, data_byte, stall_res, device_address, address_enabled, last,
      input  ready
   );
   modport sink (
      input  valid, item_kind, data_byte, stall_res, device_address, address_enabled, last,
      output ready
   );
endinterface

// ===== sv/usb_control_request_handler.sv =====
// top level of the usb endpoint-0 control request handler
// a request passes through the decode state, then its data beats and the handshake beat
// leave through the output register, one output beat per cycle unless rsp ready holds it;
// a transfer has 0 to 20 data bytes; a new request is taken once its handshake is registered
// reset: synchronous active-high; clears the address, the state memory valid bits and the
// output valid flag, and loads the id registers with their defaults
module usb_control_request_handler (
   input  logic                           clock,
   input  logic                           reset,
   usbctl_req_if.sink                     req_ch,
   usbctl_rsp_if.source                   rsp_ch,
   input  logic                           csr_we,
   input  logic [usbctl_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [15:0]                    csr_wdata
);
   import usbctl_pkg::*;

   csr_regs_type csr_ff;
   smem_req_type smem_req;
   logic [15:0]  smem_rd_data;

   // id registers, to be written only while no transfer is in flight; the block does not enforce it
   // out-of-range indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.vendor_id      <= VENDOR_ID_RST;
         csr_ff.product_id     <= PRODUCT_ID_RST;
         csr_ff.device_release <= DEVICE_RELEASE_RST;
      end else if (csr_we) begin
         if (csr_index == CSR_VENDOR_ID) begin
            csr_ff.vendor_id <= csr_wdata;
         end
         if (csr_index == CSR_PRODUCT_ID) begin
            csr_ff.product_id <= csr_wdata;
         end
         if (csr_index == CSR_DEVICE_RELEASE) begin
            csr_ff.device_release <= csr_wdata;
         end
      end
   end

   // configuration value and user value live in the state memory;
   // one read at acceptance, at most one write in the decode cycle, and
   // the next read only after the handshake, so no forwarding is needed
   usbctl_smem u_smem (
      .clock    (clock),
      .reset    (reset),
      .smem_req (smem_req),
      .rd_data  (smem_rd_data)
   );

   // decode, descriptor rom walk and the output register
   usbctl_seq u_seq (
      .clock        (clock),
      .reset        (reset),
      .req          (req_ch),
      .rsp          (rsp_ch),
      .csr          (csr_ff),
      .smem_req     (smem_req),
      .smem_rd_data (smem_rd_data)
   );

endmodule

// ===== sv/usbctl_smem.sv =====
// state memory holding the configuration value and the user value
module usbctl_smem (
   input  logic                     clock,
   input  logic                     reset,
   input  usbctl_pkg::smem_req_type smem_req,
   output logic [15:0]              rd_data
);
   import usbctl_pkg::*;

   logic [SMEM_WIDTH-1:0] mem [SMEM_DEPTH];
   logic [SMEM_DEPTH-1:0] valid_ff;
   logic [SMEM_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (smem_req.wr_en) begin
         mem[smem_req.wr_addr] <= smem_req.wr_data;
      end
   end

   // entries read as zero until first written
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (smem_req.wr_en) begin
         valid_ff[smem_req.wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (smem_req.rd_en) begin
         rd_data_ff <= valid_ff[smem_req.rd_addr] ? mem[smem_req.rd_addr] : '0;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/usbctl_seq.sv =====
// request decode and beat sequencer around the state memory
module usbctl_seq (
   input  logic                     clock,
   input  logic                     reset,
   usbctl_req_if.sink               req,
   usbctl_rsp_if.source             rsp,
   input  usbctl_pkg::csr_regs_type csr,
   output usbctl_pkg::smem_req_type smem_req,
   input  logic [15:0]              smem_rd_data
);
   import usbctl_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DEC,
      ST_SEND,
      ST_HAND
   } state_type;

   typedef enum logic [1:0] {
      SRC_ZERO,
      SRC_CONF,
      SRC_USER,
      SRC_DESC
   } src_type;

   state_type   state_ff, state_in;
   logic [7:0]  rtype_ff, rtype_in;
   logic [7:0]  code_ff, code_in;
   logic [15:0] value_ff, value_in;
   logic [15:0] length_ff, length_in;
   logic [15:0] oword_ff, oword_in;
   logic        status_ff, status_in;
   src_type     src_ff, src_in;
   dsel_type    dsel_ff, dsel_in;
   logic [4:0]  pos_ff, pos_in;
   logic [4:0]  count_ff, count_in;
   logic        hs_stall_ff, hs_stall_in;
   logic [6:0]  addr_ff, addr_in;
   logic        addr_en_ff, addr_en_in;

   logic        out_valid_ff, out_valid_in;
   logic        out_kind_ff, out_kind_in;
   logic [7:0]  out_byte_ff, out_byte_in;
   logic        out_stall_ff, out_stall_in;
   logic [6:0]  out_addr_ff, out_addr_in;
   logic        out_addr_en_ff, out_addr_en_in;
   logic        out_last_ff, out_last_in;

   dsel_type    dec_dsel;
   logic [4:0]  dec_dlen;
   logic [4:0]  dec_cut;
   logic        dec_len_ge2;
   logic        dec_ok;
   logic [4:0]  dec_n;
   src_type     dec_src;
   logic        dec_set_addr;
   logic        dec_wr_en;
   logic [SMEM_AW-1:0] dec_wr_addr;
   logic [15:0] dec_wr_data;
   logic [7:0]  cur_byte;
   logic        slot_free;

   // descriptor select and length cut
   always_comb begin
      dec_dsel = DSEL_NONE;
      if (value_ff[15:8] == DT_DEVICE && value_ff[7:0] == 8'd0) begin
         dec_dsel = DSEL_DEV;
      end else if (value_ff[15:8] == DT_CONFIG && value_ff[7:0] == 8'd0) begin
         dec_dsel = DSEL_CFG;
      end else if (value_ff[15:8] == DT_STRING) begin
         if (value_ff[7:0] == 8'd0) begin
            dec_dsel = DSEL_STR0;
         end else if (value_ff[7:0] == 8'd1) begin
            dec_dsel = DSEL_STR1;
         end else if (value_ff[7:0] == 8'd2) begin
            dec_dsel = DSEL_STR2;
         end
      end
   end

   assign dec_dlen    = desc_len(dec_dsel);
   assign dec_cut     = (length_ff < {11'd0, dec_dlen}) ? length_ff[4:0] : dec_dlen;
   assign dec_len_ge2 = (length_ff >= 16'd2);

   always_comb begin
      dec_ok       = 1'b0;
      dec_n        = 5'd0;
      dec_src      = SRC_ZERO;
      dec_set_addr = 1'b0;
      dec_wr_en    = 1'b0;
      dec_wr_addr  = ENT_CONF;
      dec_wr_data  = oword_ff;
      unique case (code_ff)
         REQ_CLEAR_FEATURE, REQ_SET_FEATURE: begin
            dec_ok = 1'b1;
         end
         REQ_GET_STATUS: begin
            if (rtype_ff == RT_STD_IN || rtype_ff == RT_STD_IN_IFACE
                || rtype_ff == RT_STD_IN_EP) begin
               dec_ok = 1'b1;
               dec_n  = 5'd2;
            end
         end
         REQ_SET_ADDRESS: begin
            if (rtype_ff == RT_STD_OUT) begin
               dec_ok       = 1'b1;
               dec_set_addr = 1'b1;
            end
         end
         REQ_GET_DESC: begin
            if (rtype_ff == RT_STD_IN && dec_dlen != 5'd0) begin
               dec_ok  = 1'b1;
               dec_n   = dec_cut;
               dec_src = SRC_DESC;
            end
         end
         REQ_SET_CONFIG: begin
            if (rtype_ff == RT_STD_OUT) begin
               dec_ok      = 1'b1;
               dec_wr_en   = 1'b1;
               dec_wr_addr = ENT_CONF;
               dec_wr_data = {8'd0, value_ff[7:0]};
            end
         end
         REQ_GET_CONFIG: begin
            if (rtype_ff == RT_STD_IN) begin
               dec_ok  = 1'b1;
               dec_n   = 5'd1;
               dec_src = SRC_CONF;
            end
         end
         REQ_VENDOR: begin
            if (rtype_ff == RT_VENDOR_OUT && dec_len_ge2) begin
               dec_ok      = 1'b1;
               dec_wr_en   = 1'b1;
               dec_wr_addr = ENT_USER;
            end else if (rtype_ff == RT_VENDOR_IN && dec_len_ge2) begin
               dec_ok  = 1'b1;
               dec_n   = 5'd2;
               dec_src = SRC_USER;
            end
         end
         default: begin
            dec_ok = 1'b0;
         end
      endcase
   end

   // byte of the data stage at the current position
   always_comb begin
      unique case (src_ff)
         SRC_ZERO: cur_byte = 8'h00;
         SRC_CONF: cur_byte = smem_rd_data[7:0];
         SRC_USER: cur_byte = pos_ff[0] ? smem_rd_data[15:8] : smem_rd_data[7:0];
         SRC_DESC: cur_byte = desc_byte(dsel_ff, pos_ff, csr);
         default:  cur_byte = 8'h00;
      endcase
   end

   assign slot_free = !out_valid_ff || rsp.ready;

   always_comb begin
      state_in       = state_ff;
      rtype_in       = rtype_ff;
      code_in        = code_ff;
      value_in       = value_ff;
      length_in      = length_ff;
      oword_in       = oword_ff;
      status_in      = status_ff;
      src_in         = src_ff;
      dsel_in        = dsel_ff;
      pos_in         = pos_ff;
      count_in       = count_ff;
      hs_stall_in    = hs_stall_ff;
      addr_in        = addr_ff;
      addr_en_in     = addr_en_ff;
      out_valid_in   = out_valid_ff && !rsp.ready;
      out_kind_in    = out_kind_ff;
      out_byte_in    = out_byte_ff;
      out_stall_in   = out_stall_ff;
      out_addr_in    = out_addr_ff;
      out_addr_en_in = out_addr_en_ff;
      out_last_in    = out_last_ff;
      smem_req       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               rtype_in         = req.request_type;
               code_in          = req.request_code;
               value_in         = req.request_value;
               length_in        = req.request_length;
               oword_in         = req.out_word;
               status_in        = req.status_out_seen;
               smem_req.rd_en   = 1'b1;
               smem_req.rd_addr = (req.request_code == REQ_VENDOR) ? ENT_USER : ENT_CONF;
               state_in         = ST_DEC;
            end
         end
         ST_DEC: begin
            smem_req.wr_en   = dec_wr_en;
            smem_req.wr_addr = dec_wr_addr;
            smem_req.wr_data = dec_wr_data;
            if (dec_set_addr) begin
               addr_in    = value_ff[6:0];
               addr_en_in = 1'b1;
            end
            src_in      = dec_src;
            dsel_in     = dec_dsel;
            pos_in      = 5'd0;
            count_in    = dec_n;
            hs_stall_in = !dec_ok || (rtype_ff[7] && !status_ff);
            state_in    = (dec_n != 5'd0) ? ST_SEND : ST_HAND;
         end
         ST_SEND: begin
            if (slot_free) begin
               out_valid_in   = 1'b1;
               out_kind_in    = 1'b0;
               out_byte_in    = cur_byte;
               out_stall_in   = 1'b0;
               out_addr_in    = addr_ff;
               out_addr_en_in = addr_en_ff;
               out_last_in    = 1'b0;
               pos_in         = pos_ff + 5'd1;
               if (pos_ff == count_ff - 5'd1) begin
                  state_in = ST_HAND;
               end
            end
         end
         ST_HAND: begin
            if (slot_free) begin
               out_valid_in   = 1'b1;
               out_kind_in    = 1'b1;
               out_byte_in    = 8'h00;
               out_stall_in   = hs_stall_ff;
               out_addr_in    = addr_ff;
               out_addr_en_in = addr_en_ff;
               out_last_in    = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         addr_ff      <= 7'd0;
         addr_en_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff       <= state_in;
         rtype_ff       <= rtype_in;
         code_ff        <= code_in;
         value_ff       <= value_in;
         length_ff      <= length_in;
         oword_ff       <= oword_in;
         status_ff      <= status_in;
         src_ff         <= src_in;
         dsel_ff        <= dsel_in;
         pos_ff         <= pos_in;
         count_ff       <= count_in;
         hs_stall_ff    <= hs_stall_in;
         addr_ff        <= addr_in;
         addr_en_ff     <= addr_en_in;
         out_valid_ff   <= out_valid_in;
         out_kind_ff    <= out_kind_in;
         out_byte_ff    <= out_byte_in;
         out_stall_ff   <= out_stall_in;
         out_addr_ff    <= out_addr_in;
         out_addr_en_ff <= out_addr_en_in;
         out_last_ff    <= out_last_in;
      end
   end

   assign req.ready           = (state_ff == ST_IDLE);
   assign rsp.valid           = out_valid_ff;
   assign rsp.item_kind       = out_kind_ff;
   assign rsp.data_byte       = out_byte_ff;
   assign rsp.stall_res       = out_stall_ff;
   assign rsp.device_address  = out_addr_ff;
   assign rsp.address_enabled = out_addr_en_ff;
   assign rsp.last            = out_last_ff;

endmodule

// ===== sv/usbctl_checker.sv =====
// port-level checker for the usb control request handler, with its bind
`include "usb_control_request_handler_macros.svh"

module usbctl_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_item_kind,
   input logic [7:0] rsp_data_byte,
   input logic       rsp_stall_res,
   input logic [6:0] rsp_device_address,
   input logic       rsp_address_enabled,
   input logic       rsp_last
);
   logic [18:0] rsp_payload;

   assign rsp_payload = {rsp_item_kind, rsp_data_byte, rsp_stall_res, rsp_device_address,
                         rsp_address_enabled, rsp_last};

   // a stalled beat holds
   `USBCTL_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload), "rsp beat changed while stalled")

   // only the handshake beat closes a transfer
   `USBCTL_ASSERT_NOW(a_last_kind, rsp_valid, rsp_last == rsp_item_kind, "last flag disagrees with beat kind")

   // data beats never carry a stall
   `USBCTL_ASSERT_NOW(a_data_no_stall, rsp_valid && !rsp_item_kind, !rsp_stall_res, "stall flag on a data beat")

   // no new request while a transfer still has its handshake to send
   `USBCTL_ASSERT_NOW(a_no_overlap, rsp_valid && !rsp_last, !req_ready, "request taken mid transfer")

   // once enabled, the address stays enabled until reset
   `USBCTL_ASSERT_NEXT(a_addr_sticky, rsp_valid && rsp_address_enabled, !rsp_valid || rsp_address_enabled, "address enable dropped")

endmodule

bind usb_control_request_handler usbctl_checker u_usbctl_checker (
   .clock               (clock),
   .reset               (reset),
   .req_ready           (req_ch.ready),
   .rsp_valid           (rsp_ch.valid),
   .rsp_ready           (rsp_ch.ready),
   .rsp_item_kind       (rsp_ch.item_kind),
   .rsp_data_byte       (rsp_ch.data_byte),
   .rsp_stall_res       (rsp_ch.stall_res),
   .rsp_device_address  (rsp_ch.device_address),
   .rsp_address_enabled (rsp_ch.address_enabled),
   .rsp_last            (rsp_ch.last)
);
